// ===== sv/i2ctra_pkg.sv =====
// ============================================================================
// i2ctra_pkg
// Shared constants and types for the I2C target register access unit.
// ============================================================================
package i2ctra_pkg;

    localparam int REG_COUNT_DEF = 64;   // default register file depth
    localparam int WORD_W        = 32;   // register word width
    localparam int IDX_FIELD_W   = 6;    // width of register index fields
    localparam int CNT_W         = 7;    // holds any REG_COUNT up to 64
    localparam int ADDR_W        = 16;   // bus byte address width
    localparam int MASK_W        = 64;   // writable mask width

    // Bus event kinds
    localparam logic [1:0] KIND_ADDR_MATCH = 2'd0;
    localparam logic [1:0] KIND_RX_BYTE    = 2'd1;
    localparam logic [1:0] KIND_TX_REQ     = 2'd2;
    localparam logic [1:0] KIND_LOCAL_UPD  = 2'd3;

    localparam logic [WORD_W-1:0] NEG_ONE_WORD = 32'hBF80_0000;
    localparam logic [7:0]        OVERRUN_BYTE = 8'hFF;
    localparam logic [2:0]        WORD_DONE_COUNT = 3'd6;

    // Register file write request
    typedef struct packed {
        logic                   en;
        logic [IDX_FIELD_W-1:0] idx;
        logic [WORD_W-1:0]      data;
    } mem_wr_t;

endpackage

// ===== sv/i2ctra_ifs.sv =====
// ============================================================================
// i2ctra interfaces
// Valid/ready channels for bus events in and result items out.
// ============================================================================
interface i2ctra_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  rx_byte;
    logic [5:0]  local_index;
    logic [31:0] local_value;

    modport source (output valid, kind, rx_byte, local_index, local_value, input ready);
    modport sink   (input valid, kind, rx_byte, local_index, local_value, output ready);
endinterface

interface i2ctra_rsp_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        write_done;
    logic [5:0]  write_index;
    logic [31:0] write_value;

    modport source (output valid, tx_valid, tx_byte, write_done, write_index, write_value,
                    input ready);
    modport sink   (input valid, tx_valid, tx_byte, write_done, write_index, write_value,
                    output ready);
endinterface

// ===== sv/i2c_target_register_access_unit.sv =====
// ============================================================================
// i2c_target_register_access_unit
// Byte-level I2C target front end to a file of 32-bit registers.
// ============================================================================
// Usage:
//   req  : one bus event item per handshake (address match, received byte,
//          transmit request, local register update).
//   rsp  : exactly one result item per event: tx_byte for a transmit
//          request, or the stored index and word when a bus write lands.
//   cfg_we / cfg_wdata : write the 64-bit writable mask; write only while
//          no event is in flight.
// Timing: an event is taken in the idle state; the register file is read
//   at that same edge (synchronous read), and ST_EXEC then computes, writes
//   back and loads the result register once the result slot is free. A
//   new event is not taken until the previous one has committed.
// Stall: the result register holds until rsp.ready; a new event can be
//   taken while a result waits, but its commit waits for the slot to free.
// Reset: all control state clears and every register reads as zero until
//   written (per-entry valid bits, no clearing pass).
// ============================================================================
module i2c_target_register_access_unit #(
    parameter int REG_COUNT = i2ctra_pkg::REG_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    i2ctra_req_if.sink                        req,
    i2ctra_rsp_if.source                      rsp,
    input  logic                              cfg_we,
    input  logic [i2ctra_pkg::MASK_W-1:0]     cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    localparam int IDXF_W = i2ctra_pkg::ADDR_W - 2;

    state_t state_reg, state_next;

    // block state
    logic [2:0]                          byte_count_reg,    byte_count_next;
    logic [i2ctra_pkg::ADDR_W-1:0]       byte_address_reg,  byte_address_next;
    logic [i2ctra_pkg::WORD_W-1:0]       assembly_word_reg, assembly_word_next;
    logic [i2ctra_pkg::WORD_W-1:0]       read_buffer_reg,   read_buffer_next;
    logic                                buffer_valid_reg,  buffer_valid_next;
    logic [i2ctra_pkg::MASK_W-1:0]       mask_reg;

    // captured event item
    logic [1:0]                          kind_reg;
    logic [7:0]                          rx_byte_reg;
    logic [5:0]                          local_index_reg;
    logic [31:0]                         local_value_reg;

    // result register
    logic                                out_valid_reg;
    logic                                tx_valid_reg,    tx_valid_next;
    logic [7:0]                          tx_byte_reg,     tx_byte_next;
    logic                                write_done_reg,  write_done_next;
    logic [5:0]                          write_index_reg, write_index_next;
    logic [31:0]                         write_value_reg, write_value_next;

    i2ctra_pkg::mem_wr_t                 mem_wr;
    logic [i2ctra_pkg::WORD_W-1:0]       rd_data;
    logic                                accept;
    logic                                out_free;
    logic                                commit;

    logic [IDXF_W-1:0]                   idx_full;
    logic                                in_range;
    logic [i2ctra_pkg::ADDR_W-1:0]       addr_plus4;
    logic                                next_in_range;
    logic [2:0]                          count_inc;
    logic [i2ctra_pkg::WORD_W-1:0]       asm_mod;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign commit    = (state_reg == ST_EXEC) && out_free;

    // Read the addressed word at acceptance; the address holds until commit.
    i2ctra_regmem #(
        .REG_COUNT (REG_COUNT)
    ) u_regmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (mem_wr),
        .rd_en   (accept),
        .rd_idx  (byte_address_reg[7:2]),
        .rd_data (rd_data)
    );

    assign idx_full      = byte_address_reg[i2ctra_pkg::ADDR_W-1:2];
    assign in_range      = idx_full < IDXF_W'(REG_COUNT);
    assign addr_plus4    = byte_address_reg + i2ctra_pkg::ADDR_W'(4);
    assign next_in_range = addr_plus4[i2ctra_pkg::ADDR_W-1:2] < IDXF_W'(REG_COUNT);
    assign count_inc     = byte_count_reg + 3'd1;

    // Place the received byte: data byte 0 lands in the top byte.
    always_comb
    begin
        asm_mod = assembly_word_reg;
        case (byte_count_reg)
            3'd2:    asm_mod[31:24] = rx_byte_reg;
            3'd3:    asm_mod[23:16] = rx_byte_reg;
            3'd4:    asm_mod[15:8]  = rx_byte_reg;
            default: asm_mod[7:0]   = rx_byte_reg;
        endcase
    end

    always_comb
    begin
        state_next         = state_reg;
        byte_count_next    = byte_count_reg;
        byte_address_next  = byte_address_reg;
        assembly_word_next = assembly_word_reg;
        read_buffer_next   = read_buffer_reg;
        buffer_valid_next  = buffer_valid_reg;
        tx_valid_next      = 1'b0;
        tx_byte_next       = '0;
        write_done_next    = 1'b0;
        write_index_next   = '0;
        write_value_next   = '0;
        mem_wr             = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    unique case (kind_reg)
                        i2ctra_pkg::KIND_ADDR_MATCH:
                        begin
                            byte_count_next    = '0;
                            byte_address_next  = '0;
                            assembly_word_next = '0;
                            buffer_valid_next  = 1'b0;
                        end
                        i2ctra_pkg::KIND_RX_BYTE:
                        begin
                            if (byte_count_reg == 3'd0)
                            begin
                                byte_address_next = {rx_byte_reg, 8'h00};
                                byte_count_next   = 3'd1;
                            end
                            else if (byte_count_reg == 3'd1)
                            begin
                                byte_address_next = byte_address_reg | {8'h00, rx_byte_reg};
                                buffer_valid_next = 1'b0;
                                byte_count_next   = 3'd2;
                            end
                            else if (count_inc == i2ctra_pkg::WORD_DONE_COUNT)
                            begin
                                // word complete: store if allowed, then advance
                                if (in_range && mask_reg[idx_full[5:0]])
                                begin
                                    mem_wr.en        = 1'b1;
                                    mem_wr.idx       = idx_full[5:0];
                                    mem_wr.data      = asm_mod;
                                    write_done_next  = 1'b1;
                                    write_index_next = idx_full[5:0];
                                    write_value_next = asm_mod;
                                end
                                assembly_word_next = '0;
                                byte_address_next  = addr_plus4;
                                byte_count_next    = next_in_range ? 3'd2 : 3'd0;
                            end
                            else
                            begin
                                assembly_word_next = asm_mod;
                                byte_count_next    = count_inc;
                            end
                        end
                        i2ctra_pkg::KIND_TX_REQ:
                        begin
                            tx_valid_next = 1'b1;
                            if (byte_count_reg == 3'd0)
                            begin
                                read_buffer_next  = in_range ? rd_data
                                                             : i2ctra_pkg::NEG_ONE_WORD;
                                buffer_valid_next = 1'b1;
                                tx_byte_next      = read_buffer_next[7:0];
                                byte_count_next   = 3'd1;
                            end
                            else if (buffer_valid_reg && (byte_count_reg < 3'd4))
                            begin
                                case (byte_count_reg[1:0])
                                    2'd1:    tx_byte_next = read_buffer_reg[15:8];
                                    2'd2:    tx_byte_next = read_buffer_reg[23:16];
                                    default: tx_byte_next = read_buffer_reg[31:24];
                                endcase
                                if (byte_count_reg == 3'd3)
                                begin
                                    byte_count_next   = 3'd0;
                                    byte_address_next = addr_plus4;
                                end
                                else
                                begin
                                    byte_count_next = count_inc;
                                end
                            end
                            else
                            begin
                                // overrun: drop the buffer
                                tx_byte_next      = i2ctra_pkg::OVERRUN_BYTE;
                                byte_count_next   = 3'd0;
                                buffer_valid_next = 1'b0;
                            end
                        end
                        i2ctra_pkg::KIND_LOCAL_UPD:
                        begin
                            mem_wr.en   = 1'b1;
                            mem_wr.idx  = local_index_reg;
                            mem_wr.data = local_value_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            byte_count_reg    <= '0;
            byte_address_reg  <= '0;
            assembly_word_reg <= '0;
            read_buffer_reg   <= '0;
            buffer_valid_reg  <= 1'b0;
            mask_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            byte_count_reg    <= byte_count_next;
            byte_address_reg  <= byte_address_next;
            assembly_word_reg <= assembly_word_next;
            read_buffer_reg   <= read_buffer_next;
            buffer_valid_reg  <= buffer_valid_next;
            if (cfg_we)
            begin
                mask_reg <= cfg_wdata;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg        <= req.kind;
            rx_byte_reg     <= req.rx_byte;
            local_index_reg <= req.local_index;
            local_value_reg <= req.local_value;
        end
        if (commit)
        begin
            tx_valid_reg    <= tx_valid_next;
            tx_byte_reg     <= tx_byte_next;
            write_done_reg  <= write_done_next;
            write_index_reg <= write_index_next;
            write_value_reg <= write_value_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.tx_valid    = tx_valid_reg;
    assign rsp.tx_byte     = tx_byte_reg;
    assign rsp.write_done  = write_done_reg;
    assign rsp.write_index = write_index_reg;
    assign rsp.write_value = write_value_reg;

endmodule

// ===== sv/i2ctra_regmem.sv =====
// ============================================================================
// i2ctra_regmem
// Register file memory, one write and one registered read per cycle, with
// per-entry valid bits so unwritten entries read as zero after reset.
// ============================================================================
module i2ctra_regmem #(
    parameter int REG_COUNT = i2ctra_pkg::REG_COUNT_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  i2ctra_pkg::mem_wr_t                    wr,
    input  logic                                   rd_en,
    input  logic [i2ctra_pkg::IDX_FIELD_W-1:0]     rd_idx,
    output logic [i2ctra_pkg::WORD_W-1:0]          rd_data
);

    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic [i2ctra_pkg::WORD_W-1:0] mem [REG_COUNT];
    logic [REG_COUNT-1:0]          vld_reg;
    logic [i2ctra_pkg::WORD_W-1:0] rd_data_reg;
    logic                          rd_vld_reg;
    logic                          wr_ok;
    logic                          rd_ok;

    assign wr_ok = wr.en && ({1'b0, wr.idx} < i2ctra_pkg::CNT_W'(REG_COUNT));
    assign rd_ok = {1'b0, rd_idx} < i2ctra_pkg::CNT_W'(REG_COUNT);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr.idx[IDX_W-1:0]] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                vld_reg[wr.idx[IDX_W-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= rd_ok && vld_reg[rd_idx[IDX_W-1:0]];
            end
        end
    end

    // never-written entries read as zero
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== sv/i2ctra_checker.sv =====
// ============================================================================
// i2ctra_checker
// Port-level checks on the register access unit, bound to the top level.
// ============================================================================
module i2ctra_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        tx_valid,
    input logic [7:0]  tx_byte,
    input logic        write_done,
    input logic [5:0]  write_index,
    input logic [31:0] write_value
);

    // hold a stalled result steady
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(tx_byte) && $stable(write_value)
                                    && $stable(write_index) && $stable(tx_valid))
        else $error("stalled result changed");

    // one event at a time: no new item right after one is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item accepted while another is in flight");

    // a result is either a transmit byte or a write report, never both
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(tx_valid && write_done))
        else $error("transmit and write report in one result");

    // unused result fields read as zero
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (tx_valid || tx_byte == 8'h00)
                      && (write_done || (write_index == 6'd0 && write_value == 32'd0)))
        else $error("unused result field not zero");

endmodule

bind i2c_target_register_access_unit i2ctra_checker u_i2ctra_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .tx_valid    (rsp.tx_valid),
    .tx_byte     (rsp.tx_byte),
    .write_done  (rsp.write_done),
    .write_index (rsp.write_index),
    .write_value (rsp.write_value)
);
